@@ sv/sha_pkg.sv @@
// ============================================================================
// SHA-256 stream hasher package
// Shared beat types, hash constants and round functions.
// ============================================================================
package sha_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    localparam logic REQ_ABSORB = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam int WORD_W    = 32;
    localparam int SCHED_DEP = 16;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6A09E667;
            3'd1: v = 32'hBB67AE85;
            3'd2: v = 32'h3C6EF372;
            3'd3: v = 32'hA54FF53A;
            3'd4: v = 32'h510E527F;
            3'd5: v = 32'h9B05688C;
            3'd6: v = 32'h1F83D9AB;
            3'd7: v = 32'h5BE0CD19;
            default: v = 32'h6A09E667;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
            32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
            32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
            32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
            32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
            32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
            32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
            32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
            32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
            32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
            32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
            32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
            32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
            32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
            32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
            32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
        return k[idx];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ sv/sha_ram.sv @@
// ============================================================================
// Generic single-port RAM
// One write or read per cycle; read data is registered.
// ============================================================================
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, or read into the registered output.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/sha256_stream_hasher.sv @@
// ============================================================================
// SHA-256 stream hasher
// Absorbs a message one byte per beat and returns its digest on finish.
// ============================================================================
// Absorb beats are taken while idle, except that the 64th byte of a block
// starts a compression during which no beat is accepted: ST_LOAD prefetches
// the first message word, ST_RUN runs 64 rounds at one round per cycle and
// a closing step, and ST_ADD adds into the chaining hash. A finish beat pads
// the message at one byte per cycle, writes the two length words, runs one or
// two compressions and then delivers eight digest beats, word 0 first, with
// last_word on word 7. The message words live in a 16-entry RAM. Bytes are
// packed into a word register before each RAM write. After the digest is taken
// the engine returns to the initial hash for a new message.
module sha256_stream_hasher (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sha_pkg::in_beat_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sha_pkg::out_beat_t   out_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;
    localparam logic [2:0] ST_LEN   = 3'd5;
    localparam logic [2:0] ST_LOAD  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg, vh_reg;
    logic [31:0] pack_reg;
    logic [5:0]  fill_reg;
    logic [60:0] total_reg;
    logic [6:0]  rnd_reg;
    logic [3:0]  pad_reg;
    logic        final_reg;
    logic        twice_reg;
    logic [2:0]  oidx_reg;

    // Schedule RAM port.
    logic        w_we;
    logic [3:0]  w_addr;
    logic [31:0] w_wdata, w_rdata;

    sha_ram #(.WIDTH(sha_pkg::WORD_W), .DEPTH(sha_pkg::SCHED_DEP)) u_sched (
        .clk  (clk),
        .we   (w_we),
        .addr (w_addr),
        .wdata(w_wdata),
        .rdata(w_rdata)
    );

    // Rolling window of w[t-16..t-1] kept in registers for the expansion.
    logic [31:0] win_reg [16];
    logic [31:0] s0, s1, wt, t1, t2, big0, big1, ch, maj;
    logic [5:0]  rnd6;

    assign rnd6 = rnd_reg[5:0];

    // Round word: loaded words for the first sixteen rounds, expanded after.
    always_comb
    begin
        s0 = sha_pkg::rotr(win_reg[1], 7) ^ sha_pkg::rotr(win_reg[1], 18)
            ^ (win_reg[1] >> 3);
        s1 = sha_pkg::rotr(win_reg[14], 17) ^ sha_pkg::rotr(win_reg[14], 19)
            ^ (win_reg[14] >> 10);
        if (rnd_reg < 7'd16)
        begin
            wt = w_rdata;
        end
        else
        begin
            wt = win_reg[0] + s0 + win_reg[9] + s1;
        end
        big1 = sha_pkg::rotr(ve_reg, 6) ^ sha_pkg::rotr(ve_reg, 11)
            ^ sha_pkg::rotr(ve_reg, 25);
        ch   = (ve_reg & vf_reg) ^ (~ve_reg & vg_reg);
        t1   = vh_reg + big1 + ch + sha_pkg::round_k(rnd6) + wt;
        big0 = sha_pkg::rotr(va_reg, 2) ^ sha_pkg::rotr(va_reg, 13)
            ^ sha_pkg::rotr(va_reg, 22);
        maj  = (va_reg & vb_reg) ^ (va_reg & vc_reg) ^ (vb_reg & vc_reg);
        t2   = big0 + maj;
    end

    // Byte packing for absorb and pad.
    logic [7:0]  pbyte;
    logic [31:0] packed_word;
    logic [63:0] bitlen;

    assign bitlen = {total_reg, 3'b000};

    always_comb
    begin
        packed_word = pack_reg;
        unique case (fill_reg[1:0])
            2'd0: packed_word[31:24] = pbyte;
            2'd1: packed_word[23:16] = pbyte;
            2'd2: packed_word[15:8]  = pbyte;
            2'd3: packed_word[7:0]   = pbyte;
            default: packed_word = pack_reg;
        endcase
    end

    logic in_fire, out_fire;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_fire  = out_valid && out_ready;

    assign out_data.digest_word = h_reg[oidx_reg];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = (oidx_reg == 3'd7);

    // RAM control.
    always_comb
    begin
        w_we    = 1'b0;
        w_addr  = rnd_reg[3:0];
        w_wdata = packed_word;
        pbyte   = in_data.data_byte;
        if (state_reg == ST_PAD)
        begin
            pbyte = (pad_reg == 4'd0) ? 8'h80 : 8'h00;
        end
        priority if (state_reg == ST_IDLE)
        begin
            w_addr = fill_reg[5:2];
            w_we   = in_fire && (in_data.req_type == sha_pkg::REQ_ABSORB)
                && (fill_reg[1:0] == 2'd3);
        end
        else if (state_reg == ST_PAD)
        begin
            w_addr = fill_reg[5:2];
            w_we   = (fill_reg[1:0] == 2'd3);
        end
        else if (state_reg == ST_LEN)
        begin
            w_addr  = pad_reg[0] ? 4'd15 : 4'd14;
            w_wdata = pad_reg[0] ? bitlen[31:0] : bitlen[63:32];
            w_we    = 1'b1;
        end
        else if (state_reg == ST_LOAD)
        begin
            // Prefetch word 0 so that it is ready for the first round.
            w_addr = 4'd0;
        end
        else
        begin
            w_addr = rnd_reg[3:0] + 4'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_data.req_type == sha_pkg::REQ_FINISH)
                begin
                    state_next = ST_PAD;
                end
                else if (in_fire && fill_reg == 6'd63)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_LOAD;
                end
                else if (fill_reg == 6'd55 && !twice_reg)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (pad_reg[0])
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (rnd_reg == 7'd64)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (twice_reg)
                begin
                    state_next = ST_PAD;
                end
                else if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_fire && oidx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            total_reg <= '0;
            rnd_reg   <= '0;
            pad_reg   <= '0;
            final_reg <= 1'b0;
            twice_reg <= 1'b0;
            oidx_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    rnd_reg <= '0;
                    pad_reg <= '0;
                    if (in_fire)
                    begin
                        if (in_data.req_type == sha_pkg::REQ_FINISH)
                        begin
                            final_reg <= 1'b1;
                        end
                        else
                        begin
                            fill_reg  <= fill_reg + 6'd1;
                            total_reg <= total_reg + 61'd1;
                        end
                    end
                end
                ST_PAD:
                begin
                    rnd_reg  <= '0;
                    fill_reg <= fill_reg + 6'd1;
                    // The length words follow byte 55 on the last block.
                    if (fill_reg == 6'd55 && !twice_reg)
                    begin
                        pad_reg <= 4'd0;
                    end
                    else
                    begin
                        pad_reg <= 4'd1;
                    end
                    // Padding that reaches the block end leaves no room for the length.
                    if (fill_reg == 6'd63)
                    begin
                        twice_reg <= 1'b1;
                    end
                end
                ST_LEN:
                begin
                    pad_reg <= {3'b000, ~pad_reg[0]};
                    rnd_reg <= '0;
                end
                ST_LOAD:
                begin
                    rnd_reg <= '0;
                end
                ST_RUN:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                end
                ST_ADD:
                begin
                    h_reg[0] <= h_reg[0] + va_reg;
                    h_reg[1] <= h_reg[1] + vb_reg;
                    h_reg[2] <= h_reg[2] + vc_reg;
                    h_reg[3] <= h_reg[3] + vd_reg;
                    h_reg[4] <= h_reg[4] + ve_reg;
                    h_reg[5] <= h_reg[5] + vf_reg;
                    h_reg[6] <= h_reg[6] + vg_reg;
                    h_reg[7] <= h_reg[7] + vh_reg;
                    fill_reg  <= '0;
                    pad_reg   <= 4'd1;
                    twice_reg <= 1'b0;
                end
                ST_OUT:
                begin
                    if (out_fire)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            final_reg <= 1'b0;
                            fill_reg  <= '0;
                            total_reg <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha_pkg::init_hash(3'(i));
                            end
                        end
                    end
                end
                default: rnd_reg <= '0;
            endcase
        end
    end

    // Byte packing register and working variables.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ADD)
        begin
            pack_reg <= 32'd0;
        end
        else if ((state_reg == ST_IDLE && in_fire
                && in_data.req_type == sha_pkg::REQ_ABSORB)
            || state_reg == ST_PAD)
        begin
            pack_reg <= (fill_reg[1:0] == 2'd3) ? 32'd0 : packed_word;
        end
        if (state_reg != ST_RUN)
        begin
            va_reg <= h_reg[0];
            vb_reg <= h_reg[1];
            vc_reg <= h_reg[2];
            vd_reg <= h_reg[3];
            ve_reg <= h_reg[4];
            vf_reg <= h_reg[5];
            vg_reg <= h_reg[6];
            vh_reg <= h_reg[7];
        end
        else if (rnd_reg != 7'd64)
        begin
            vh_reg <= vg_reg;
            vg_reg <= vf_reg;
            vf_reg <= ve_reg;
            ve_reg <= vd_reg + t1;
            vd_reg <= vc_reg;
            vc_reg <= vb_reg;
            vb_reg <= va_reg;
            va_reg <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= wt;
        end
    end

    // The RAM holds a full block of words; a padded word is written whenever
    // padding passes a word boundary, so stale data is never compressed.

endmodule
